>>> hdl/ray_sphere_intersect_core_macros.svh
// Assertion macros for the ray/sphere intersection core.
// Used by the top level; expects a clock and an active-low reset as arguments.
`ifndef RAY_SPHERE_INTERSECT_CORE_MACROS_SVH
`define RAY_SPHERE_INTERSECT_CORE_MACROS_SVH

// plain property, checked on every rising clock edge outside reset
`define RSI_ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// overlapping implication
`define RSI_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) ante |-> cons) else $error(msg);

`endif

>>> hdl/rsi_pkg.sv
// Shared widths, stage types and step functions for the ray/sphere core.
// No dependencies; imported by the sqrt cell, the divider cell, the top level and the bench.
`timescale 1ns / 1ps
`default_nettype none

package rsi_pkg;

	localparam int COORD_W = 32;
	localparam int RAD_W = 31;
	localparam int A_W = 64;                // d.d, unsigned
	localparam int H_W = 66;                // d.oc, signed
	localparam int C_W = 67;                // oc.oc - r^2, signed
	localparam int D_W = 132;               // h^2 - a*c, signed
	localparam int ROOT_W = 65;             // floor(sqrt(D))
	localparam int RADC_W = 2 * ROOT_W;     // radicand bits
	localparam int SREM_W = ROOT_W + 2;
	localparam int Q_W = 33;                // quotient bits per root
	localparam int T_W = 32;
	localparam int FRAC_BITS_DEF = 16;

	localparam int USER_HIT = 0;
	localparam int USER_DEG = 1;

	localparam logic [Q_W-1:0] Q_POS_LIM = Q_W'(1) << (T_W - 1);
	localparam logic [Q_W:0] Q_NEG_LIM = (Q_W + 1)'(1) << (T_W - 1);
	localparam logic [T_W-1:0] T_MAX = {1'b0, {(T_W - 1){1'b1}}};
	localparam logic [T_W-1:0] T_MIN = {1'b1, {(T_W - 1){1'b0}}};

	typedef struct packed {
		logic [H_W-1:0] h;
		logic [A_W-1:0] a;
		logic deg;
		logic dneg;
		logic [RADC_W-1:0] rad;
		logic [SREM_W-1:0] rem;
		logic [ROOT_W-1:0] root;
	} sq_t;

	typedef struct packed {
		logic neg;
		logic ovf;
		logic [A_W-1:0] r;
		logic [Q_W-1:0] mlo;
		logic [Q_W-1:0] q;
	} div_lane_t;

	typedef struct packed {
		logic [A_W-1:0] a;
		logic deg;
		logic hit;
		div_lane_t near;
		div_lane_t far;
	} dv_t;

	// one restoring division step: bring down the next magnitude bit
	function automatic div_lane_t div_step(div_lane_t l, logic [A_W-1:0] a);
		logic [A_W:0] t;
		logic ge;
		div_lane_t n;
		t = {l.r, l.mlo[Q_W-1]};
		ge = (t >= {1'b0, a});
		n = l;
		n.r = ge ? A_W'(t - {1'b0, a}) : t[A_W-1:0];
		n.mlo = {l.mlo[Q_W-2:0], 1'b0};
		n.q = {l.q[Q_W-2:0], ge};
		return n;
	endfunction

	// floor toward minus infinity and saturate to 32 bit signed
	function automatic logic [T_W-1:0] div_result(div_lane_t l);
		logic [Q_W:0] qq;
		logic [T_W-1:0] res;
		qq = {1'b0, l.q} + {{Q_W{1'b0}}, (l.r != '0)};
		if (!l.neg) begin
			if (l.ovf || l.q >= Q_POS_LIM) res = T_MAX;
			else res = l.q[T_W-1:0];
		end else begin
			if (l.ovf || qq > Q_NEG_LIM) res = T_MIN;
			else res = ~qq[T_W-1:0] + 1'b1;
		end
		return res;
	endfunction

endpackage

`default_nettype wire

>>> hdl/ray_sphere_intersect_core.sv
// Ray/sphere intersection, fully pipelined: one ray/sphere pair per clock cycle, through 6
// front stages for the products, sums and discriminant, a row of 65 square-root cells, one
// numerator stage, a row of 33 divider cells and the output register. All stages advance
// together; while a result waits on the output the whole pipe holds. Coordinates are signed
// Q16.16 (FRAC_BITS fractional bits); t values are floored and saturated, and zero when
// there is no hit.
`timescale 1ns / 1ps
`default_nettype none
`include "ray_sphere_intersect_core_macros.svh"

module ray_sphere_intersect_core import rsi_pkg::*; #(
	parameter int unsigned FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic s_axis_tvalid,
	output logic s_axis_tready,
	// origin_x, origin_y, origin_z, dir_x, dir_y, dir_z, center_x, center_y, center_z,
	// radius, one zero pad bit
	input  logic [319:0] s_axis_tdata,
	output logic m_axis_tvalid,
	input  logic m_axis_tready,
	// t_near, t_far
	output logic [63:0] m_axis_tdata,
	// hit, degenerate
	output logic [1:0] m_axis_tuser
);

	localparam int NUM_W = H_W + 1;
	localparam int M_W = NUM_W + FRAC_BITS;
	localparam int OVF_W = (M_W > A_W + Q_W) ? M_W : A_W + Q_W;
	localparam int HL_W = 33;
	localparam int AL_W = 32;
	localparam int CL_W = 34;

	logic adv;
	assign adv = !m_axis_tvalid || m_axis_tready;
	assign s_axis_tready = adv;

	// s1: register operands, oc = origin - center
	logic vld_s1;
	logic signed [COORD_W-1:0] d_s1 [3];
	logic signed [COORD_W:0] oc_s1 [3];
	logic [RAD_W-1:0] r_s1;
	logic deg_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s1 <= 1'b0;
		else if (adv) vld_s1 <= s_axis_tvalid;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 3; i++) begin
				d_s1[i] <= $signed(s_axis_tdata[(3 + i) * COORD_W +: COORD_W]);
				oc_s1[i] <= $signed({s_axis_tdata[i * COORD_W + COORD_W - 1],
					s_axis_tdata[i * COORD_W +: COORD_W]})
					- $signed({s_axis_tdata[(6 + i) * COORD_W + COORD_W - 1],
					s_axis_tdata[(6 + i) * COORD_W +: COORD_W]});
			end
			r_s1 <= s_axis_tdata[9 * COORD_W +: RAD_W];
			deg_s1 <= (s_axis_tdata[6 * COORD_W - 1 : 3 * COORD_W] == '0);
		end
	end

	// s2: component products
	logic vld_s2, deg_s2;
	logic signed [2*COORD_W-1:0] dd_s2 [3];
	logic signed [2*COORD_W:0] doc_s2 [3];
	logic signed [2*COORD_W+1:0] oo_s2 [3];
	logic [2*RAD_W-1:0] rr_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s2 <= 1'b0;
		else if (adv) vld_s2 <= vld_s1;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 3; i++) begin
				dd_s2[i] <= d_s1[i] * d_s1[i];
				doc_s2[i] <= d_s1[i] * oc_s1[i];
				oo_s2[i] <= oc_s1[i] * oc_s1[i];
			end
			rr_s2 <= r_s1 * r_s1;
			deg_s2 <= deg_s1;
		end
	end

	// s3: quadratic terms a, h (half b), c
	logic vld_s3, deg_s3;
	logic [A_W-1:0] a_s3;
	logic signed [H_W-1:0] h_s3;
	logic signed [C_W-1:0] c_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s3 <= 1'b0;
		else if (adv) vld_s3 <= vld_s2;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			a_s3 <= A_W'(dd_s2[0]) + A_W'(dd_s2[1]) + A_W'(dd_s2[2]);
			h_s3 <= H_W'(doc_s2[0]) + H_W'(doc_s2[1]) + H_W'(doc_s2[2]);
			c_s3 <= C_W'(oo_s2[0]) + C_W'(oo_s2[1]) + C_W'(oo_s2[2])
				- $signed(C_W'(rr_s2));
			deg_s3 <= deg_s2;
		end
	end

	// s4: partial products of h*h and a*c
	logic vld_s4, deg_s4;
	logic [A_W-1:0] a_s4;
	logic [H_W-1:0] h_s4;
	logic signed [2*HL_W-1:0] pp_hh_s4;
	logic signed [2*HL_W:0] pp_hm_s4;
	logic [2*HL_W-1:0] pp_ll_s4;
	logic signed [2*HL_W-1:0] ac_hh_s4;
	logic [AL_W+CL_W-1:0] ac_hl_s4;
	logic signed [2*HL_W-1:0] ac_lh_s4;
	logic [AL_W+CL_W-1:0] ac_ll_s4;

	logic signed [H_W-HL_W-1:0] hh;
	logic [HL_W-1:0] hl;
	logic [A_W-AL_W-1:0] ah;
	logic [AL_W-1:0] al;
	logic signed [C_W-CL_W-1:0] ch;
	logic [CL_W-1:0] cl;

	assign hh = h_s3[H_W-1:HL_W];
	assign hl = h_s3[HL_W-1:0];
	assign ah = a_s3[A_W-1:AL_W];
	assign al = a_s3[AL_W-1:0];
	assign ch = c_s3[C_W-1:CL_W];
	assign cl = c_s3[CL_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s4 <= 1'b0;
		else if (adv) vld_s4 <= vld_s3;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			pp_hh_s4 <= hh * hh;
			pp_hm_s4 <= hh * $signed({1'b0, hl});
			pp_ll_s4 <= hl * hl;
			ac_hh_s4 <= $signed({1'b0, ah}) * ch;
			ac_hl_s4 <= ah * cl;
			ac_lh_s4 <= $signed({1'b0, al}) * ch;
			ac_ll_s4 <= al * cl;
			a_s4 <= a_s3;
			h_s4 <= h_s3;
			deg_s4 <= deg_s3;
		end
	end

	// s5: h^2 and a*c
	logic vld_s5, deg_s5;
	logic [A_W-1:0] a_s5;
	logic [H_W-1:0] h_s5;
	logic [D_W-1:0] hsq_s5;
	logic [D_W-1:0] ac_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s5 <= 1'b0;
		else if (adv) vld_s5 <= vld_s4;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			hsq_s5 <= (D_W'(pp_hh_s4) << (2 * HL_W)) + (D_W'(pp_hm_s4) << (HL_W + 1))
				+ D_W'(pp_ll_s4);
			ac_s5 <= (D_W'(ac_hh_s4) << (AL_W + CL_W)) + (D_W'(ac_hl_s4) << AL_W)
				+ (D_W'(ac_lh_s4) << CL_W) + D_W'(ac_ll_s4);
			a_s5 <= a_s4;
			h_s5 <= h_s4;
			deg_s5 <= deg_s4;
		end
	end

	// s6: discriminant (quarter of b^2 - 4ac)
	logic vld_s6;
	sq_t sq_s6;
	logic [D_W-1:0] disc;

	assign disc = hsq_s5 - ac_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s6 <= 1'b0;
		else if (adv) vld_s6 <= vld_s5;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			sq_s6.h <= h_s5;
			sq_s6.a <= a_s5;
			sq_s6.deg <= deg_s5;
			sq_s6.dneg <= disc[D_W-1];
			sq_s6.rad <= disc[RADC_W-1:0];
			sq_s6.rem <= '0;
			sq_s6.root <= '0;
		end
	end

	// square root row
	logic sq_vld [ROOT_W+1];
	sq_t sq_d [ROOT_W+1];

	assign sq_vld[0] = vld_s6;
	assign sq_d[0] = sq_s6;

	for (genvar k = 0; k < ROOT_W; k++) begin : g_sqrt
		rsi_sqrt_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.en      (adv),
			.vld_in  (sq_vld[k]),
			.d_in    (sq_d[k]),
			.vld_out (sq_vld[k+1]),
			.d_out   (sq_d[k+1])
		);
	end

	// s7: numerators (-h -/+ s) << FRAC_BITS, split into sign and magnitude
	function automatic div_lane_t lane_init(logic [NUM_W-1:0] n, logic [A_W-1:0] a);
		logic [M_W-1:0] sn;
		logic [M_W-1:0] m;
		div_lane_t l;
		sn = {n, {FRAC_BITS{1'b0}}};
		m = sn[M_W-1] ? (~sn + 1'b1) : sn;
		l.neg = sn[M_W-1];
		l.ovf = (OVF_W'(m) >= OVF_W'({a, {Q_W{1'b0}}}));
		l.r = A_W'(m >> Q_W);
		l.mlo = m[Q_W-1:0];
		l.q = '0;
		return l;
	endfunction

	sq_t sq_end;
	logic [NUM_W-1:0] neg_h, root_x, num_near, num_far;
	logic vld_s7;
	dv_t dv_s7;

	assign sq_end = sq_d[ROOT_W];
	assign neg_h = ~{sq_end.h[H_W-1], sq_end.h} + 1'b1;
	assign root_x = {2'b00, sq_end.root};
	assign num_near = neg_h - root_x;
	assign num_far = neg_h + root_x;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s7 <= 1'b0;
		else if (adv) vld_s7 <= sq_vld[ROOT_W];
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			dv_s7.a <= sq_end.a;
			dv_s7.deg <= sq_end.deg;
			dv_s7.hit <= !sq_end.deg && !sq_end.dneg;
			dv_s7.near <= lane_init(num_near, sq_end.a);
			dv_s7.far <= lane_init(num_far, sq_end.a);
		end
	end

	// divider row
	logic dv_vld [Q_W+1];
	dv_t dv_d [Q_W+1];

	assign dv_vld[0] = vld_s7;
	assign dv_d[0] = dv_s7;

	for (genvar k = 0; k < Q_W; k++) begin : g_div
		rsi_div_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.en      (adv),
			.vld_in  (dv_vld[k]),
			.d_in    (dv_d[k]),
			.vld_out (dv_vld[k+1]),
			.d_out   (dv_d[k+1])
		);
	end

	// output register
	dv_t dv_end;
	logic out_vld_q;
	logic [63:0] tdata_q;
	logic [1:0] tuser_q;

	assign dv_end = dv_d[Q_W];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_vld_q <= 1'b0;
		else if (adv) out_vld_q <= dv_vld[Q_W];
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			tdata_q <= dv_end.hit ? {div_result(dv_end.far), div_result(dv_end.near)} : '0;
			tuser_q[USER_HIT] <= dv_end.hit;
			tuser_q[USER_DEG] <= dv_end.deg;
		end
	end

	assign m_axis_tvalid = out_vld_q;
	assign m_axis_tdata = tdata_q;
	assign m_axis_tuser = tuser_q;

	`RSI_ASSERT_IMPL(a_nohit_zero, clk, arst_n, m_axis_tvalid && !m_axis_tuser[USER_HIT], m_axis_tdata == '0, "t values not zero without hit")
	`RSI_ASSERT_CLK(a_flags_excl, clk, arst_n, !(m_axis_tvalid && m_axis_tuser[USER_HIT] && m_axis_tuser[USER_DEG]), "hit flagged on degenerate ray")
	`RSI_ASSERT_IMPL(a_root_order, clk, arst_n, m_axis_tvalid && m_axis_tuser[USER_HIT], $signed(m_axis_tdata[31:0]) <= $signed(m_axis_tdata[63:32]), "t_near above t_far")

endmodule

`default_nettype wire

>>> hdl/rsi_sqrt_cell.sv
// One cell of the integer square root row: settles one root bit per cycle while en is high.
// Depends on rsi_pkg (sq_t and widths).
`timescale 1ns / 1ps
`default_nettype none

module rsi_sqrt_cell import rsi_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic en,
	input  logic vld_in,
	input  sq_t  d_in,
	output logic vld_out,
	output sq_t  d_out
);

	logic [SREM_W-1:0] tmp;
	logic [SREM_W-1:0] trial;
	logic ge;
	sq_t nxt;

	always_comb begin
		tmp = {d_in.rem[SREM_W-3:0], d_in.rad[RADC_W-1 -: 2]};
		trial = {d_in.root, 2'b01};
		ge = (tmp >= trial);
		nxt = d_in;
		nxt.rad = {d_in.rad[RADC_W-3:0], 2'b00};
		nxt.rem = ge ? (tmp - trial) : tmp;
		nxt.root = {d_in.root[ROOT_W-2:0], ge};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_out <= 1'b0;
		else if (en) vld_out <= vld_in;
	end

	always_ff @(posedge clk) begin
		if (en) d_out <= nxt;
	end

endmodule

`default_nettype wire

>>> hdl/rsi_div_cell.sv
// One cell of the divider row: one quotient bit for both roots per cycle while en is high.
// Depends on rsi_pkg (dv_t, div_step).
`timescale 1ns / 1ps
`default_nettype none

module rsi_div_cell import rsi_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic en,
	input  logic vld_in,
	input  dv_t  d_in,
	output logic vld_out,
	output dv_t  d_out
);

	dv_t nxt;

	always_comb begin
		nxt = d_in;
		nxt.near = div_step(d_in.near, d_in.a);
		nxt.far = div_step(d_in.far, d_in.a);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_out <= 1'b0;
		else if (en) vld_out <= vld_in;
	end

	always_ff @(posedge clk) begin
		if (en) d_out <= nxt;
	end

endmodule

`default_nettype wire

>>> tb/tb_ray_sphere_intersect_core.sv
// Self-checking bench for the ray/sphere intersection core: directed and random ray/sphere
// pairs, a behavioral predictor of the hit flags and roots, and a scoreboard of results.
// Depends on rsi_pkg and ray_sphere_intersect_core.
`timescale 1ns / 1ps

module tb_ray_sphere_intersect_core;
	import rsi_pkg::*;

	localparam int FB = 16;
	localparam int LATENCY = 106;
	localparam longint CYCLE_LIMIT = 400000;

	typedef struct packed {
		logic hit;
		logic deg;
		logic [31:0] t_near;
		logic [31:0] t_far;
	} isect_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	logic [319:0] s_axis_tdata = '0;
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	logic [63:0] m_axis_tdata;
	logic [1:0] m_axis_tuser;

	ray_sphere_intersect_core DUT (.*);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	logic [319:0] ray_q[$];
	isect_t isect_q[$];
	int send_idle_pct = 0, recv_idle_pct = 0;
	int recv_hold = 0;
	bit send_pause = 0;
	bit in_taken = 0;
	int mismatches = 0;
	longint cycles = 0;

	// floor(n / a) for a > 0, saturated to 32 bit signed
	function automatic logic [31:0] floor_div_sat(logic signed [199:0] n, logic signed [199:0] a);
		logic signed [199:0] q;
		q = n / a;
		if (q * a != n && n < 0) q = q - 1;
		if (q > 200'sd2147483647) return 32'h7fffffff;
		if (q < -200'sd2147483648) return 32'h80000000;
		return q[31:0];
	endfunction

	function automatic isect_t predict_isect(logic [319:0] p);
		logic signed [199:0] dv[3], oc[3], a, h, c, r, disc, s, cand;
		isect_t res;
		a = 0; h = 0; c = 0;
		for (int i = 0; i < 3; i++) begin
			dv[i] = 200'(signed'(p[32*(3+i) +: 32]));
			oc[i] = 200'(signed'(p[32*i +: 32])) - 200'(signed'(p[32*(6+i) +: 32]));
			a += dv[i] * dv[i];
			h += dv[i] * oc[i];
			c += oc[i] * oc[i];
		end
		r = 200'(p[288 +: 31]);
		c -= r * r;
		res = '0;
		if (a == 0) begin
			res.deg = 1'b1;
			return res;
		end
		disc = h * h - a * c;
		if (disc < 0) return res;
		s = 0;
		for (int i = 70; i >= 0; i--) begin
			cand = s | (200'sd1 << i);
			if (cand * cand <= disc) s = cand;
		end
		res.hit = 1'b1;
		res.t_near = floor_div_sat((-h - s) <<< FB, a);
		res.t_far = floor_div_sat((-h + s) <<< FB, a);
		return res;
	endfunction

	function automatic logic [31:0] rand_coord();
		case ($urandom_range(0, 5))
			0: return 32'h7fffffff;
			1: return 32'h80000000;
			2: return $urandom();
			default: return 32'($signed($urandom_range(0, 40 << FB)) - (20 << FB));
		endcase
	endfunction

	function automatic logic [319:0] make_ray(logic [31:0] o[3], logic [31:0] d[3],
			logic [31:0] cc[3], logic [30:0] rad);
		logic [319:0] p;
		p = '0;
		for (int i = 0; i < 3; i++) begin
			p[32*i +: 32] = o[i];
			p[32*(3+i) +: 32] = d[i];
			p[32*(6+i) +: 32] = cc[i];
		end
		p[288 +: 31] = rad;
		return p;
	endfunction

	// driver
	always @(negedge clk) begin
		if (arst_n) begin
			if (!s_axis_tvalid || in_taken) begin
				if (ray_q.size() > 0 && !send_pause && $urandom_range(0, 99) >= send_idle_pct) begin
					s_axis_tdata <= ray_q[0];
					s_axis_tvalid <= 1'b1;
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
			if (recv_hold > 0) begin
				recv_hold <= recv_hold - 1;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
			end
		end
	end

	// input acceptance and output monitor
	always @(posedge clk) begin
		cycles <= cycles + 1;
		in_taken <= arst_n && s_axis_tvalid && s_axis_tready;
		if (arst_n && s_axis_tvalid && s_axis_tready) begin
			isect_q.push_back(predict_isect(s_axis_tdata));
			void'(ray_q.pop_front());
		end
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			isect_t got, exp_r;
			got = {m_axis_tuser[USER_HIT], m_axis_tuser[USER_DEG], m_axis_tdata[31:0],
				m_axis_tdata[63:32]};
			if (isect_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected transaction %h", got);
			end else begin
				exp_r = isect_q.pop_front();
				if (got !== exp_r) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: exp hit=%b deg=%b near=%h far=%h, got hit=%b deg=%b near=%h far=%h",
							exp_r.hit, exp_r.deg, exp_r.t_near, exp_r.t_far,
							got.hit, got.deg, got.t_near, got.t_far);
				end
			end
		end
		if (cycles > CYCLE_LIMIT) begin
			$display("** ray_sphere_intersect_core: FAILED **");
			$finish;
		end
	end

	task automatic wait_drained();
		while (ray_q.size() > 0 || s_axis_tvalid || isect_q.size() > 0) @(posedge clk);
	endtask

	task automatic add_random(int n);
		logic [31:0] o[3], d[3], cc[3];
		logic [30:0] rad;
		for (int k = 0; k < n; k++) begin
			for (int i = 0; i < 3; i++) begin
				o[i] = rand_coord();
				d[i] = ($urandom_range(0, 19) == 0) ? 32'h0 : rand_coord();
				cc[i] = ($urandom_range(0, 2) == 0) ? o[i] + rand_coord() : rand_coord();
			end
			case ($urandom_range(0, 3))
				0: rad = $urandom();
				1: rad = 31'h7fffffff;
				default: rad = $urandom_range(0, 30 << FB);
			endcase
			ray_q.push_back(make_ray(o, d, cc, rad));
		end
	endtask

	initial begin
		logic [31:0] o[3], d[3], cc[3];
		logic [31:0] one;
		one = 32'h1 << FB;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// directed: head-on hit, miss, tangent, inside, degenerate, extremes
		o = '{0, 0, -(5 * one)}; d = '{0, 0, one}; cc = '{0, 0, 0};
		ray_q.push_back(make_ray(o, d, cc, one));
		o = '{3 * one, 0, -(5 * one)};
		ray_q.push_back(make_ray(o, d, cc, one));
		o = '{one, 0, -(5 * one)};
		ray_q.push_back(make_ray(o, d, cc, one));
		o = '{0, 0, 0};
		ray_q.push_back(make_ray(o, d, cc, 2 * one));
		d = '{0, 0, 0};
		ray_q.push_back(make_ray(o, d, cc, one));
		d = '{1, 0, 0};
		ray_q.push_back(make_ray(o, d, cc, 31'h7fffffff));
		d = '{32'h80000000, 32'h80000000, 32'h80000000};
		o = '{32'h7fffffff, 32'h7fffffff, 32'h7fffffff};
		cc = '{32'h80000000, 32'h80000000, 32'h80000000};
		ray_q.push_back(make_ray(o, d, cc, 31'h7fffffff));
		ray_q.push_back(make_ray(o, d, cc, 0));
		d = '{32'h7fffffff, 32'h7fffffff, 32'h7fffffff};
		ray_q.push_back(make_ray(o, d, cc, 31'h7fffffff));
		ray_q.push_back(make_ray(cc, d, o, 31'h7fffffff));
		ray_q.push_back(make_ray(cc, '{32'hffffffff, 0, 0}, o, 31'h55555555));
		ray_q.push_back(make_ray('{32'hffffffff, 32'hffffffff, 32'hffffffff},
			'{32'hffffffff, 32'hffffffff, 32'hffffffff}, '{0, 0, 0}, 31'h2aaaaaaa));
		wait_drained();

		send_idle_pct = 38; recv_idle_pct = 47;
		add_random(300);
		// long receiver stall while the sender keeps offering
		recv_hold = 400;
		wait_drained();
		// sender paused until all results have come
		send_pause = 1;
		add_random(20);
		while (isect_q.size() > 0) @(posedge clk);
		send_pause = 0;

		send_idle_pct = 47; recv_idle_pct = 38;
		add_random(300);
		wait_drained();
		send_idle_pct = 0; recv_idle_pct = 0;
		add_random(320);
		wait_drained();
		repeat (LATENCY + 20) @(posedge clk);

		if (mismatches == 0) $display("** ray_sphere_intersect_core: PASSED **");
		else $display("** ray_sphere_intersect_core: FAILED **");
		$finish;
	end

endmodule

>>> files.f
+incdir+hdl
hdl/rsi_pkg.sv
hdl/rsi_sqrt_cell.sv
hdl/rsi_div_cell.sv
hdl/ray_sphere_intersect_core.sv
tb/tb_ray_sphere_intersect_core.sv
